FILE: rtl/lbc_pkg.sv
package lbc_pkg;

    // coordinate width of every segment, window and result coordinate field
    localparam int CoordBits = 16;

    typedef logic signed [CoordBits-1:0] t_coord;

    // one segment to clip
    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg;

    // one clipped segment
    typedef struct packed {
        logic   accepted;
        t_coord clip_start_x;
        t_coord clip_start_y;
        t_coord clip_end_x;
        t_coord clip_end_y;
    } t_clip;

    // window register indexes
    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_TOP    = 2'd3
    } t_reg_idx;

    localparam t_coord WinLeftRst   = 16'sd100;
    localparam t_coord WinBottomRst = 16'sd100;
    localparam t_coord WinRightRst  = 16'sd400;
    localparam t_coord WinTopRst    = 16'sd400;

endpackage

FILE: rtl/lbc_div.sv
// Pipelined restoring divider: o_quo = floor(i_num * 2^FracBits / i_den),
// valid when i_num < 4 * i_den. One quotient bit per stage.
module lbc_div #(
    parameter int MagBits  = 17,
    parameter int FracBits = 20
) (
    input  logic                  i_clk,
    input  logic [MagBits-1:0]    i_num,
    input  logic [MagBits-1:0]    i_den,
    output logic [FracBits+1:0]   o_quo
);

    localparam int Steps = FracBits + 2;

    logic [MagBits-1:0] r_rem [Steps];
    logic [MagBits-1:0] r_den [Steps];
    logic [1:0]         r_lo  [Steps];
    logic [Steps-1:0]   r_quo [Steps];

    for (genvar j = 0; j < Steps; j++) begin : g_step
        logic [MagBits-1:0] rem_in;
        logic [MagBits-1:0] den_in;
        logic [1:0]         lo_in;
        logic [Steps-1:0]   quo_in;
        logic [MagBits:0]   shifted;
        logic [MagBits:0]   diff;
        logic               ge;
        logic [MagBits-1:0] n_rem;

        if (j == 0) begin : g_first
            // the top partial remainder is the numerator without its two low bits
            assign rem_in = {2'b00, i_num[MagBits-1:2]};
            assign den_in = i_den;
            assign lo_in  = i_num[1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign lo_in  = r_lo[j-1];
            assign quo_in = r_quo[j-1];
        end

        // shift in the next dividend bit, compare and subtract
        always_comb begin
            shifted = {rem_in, lo_in[1]};
            diff    = shifted - {1'b0, den_in};
            ge      = (shifted >= {1'b0, den_in});
            n_rem   = ge ? diff[MagBits-1:0] : shifted[MagBits-1:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= n_rem;
            r_den[j] <= den_in;
            r_lo[j]  <= {lo_in[0], 1'b0};
            r_quo[j] <= {quo_in[Steps-2:0], ge};
        end
    end

    assign o_quo = r_quo[Steps-1];

endmodule

FILE: rtl/liang_barsky_line_clip_core.sv
// Liang-Barsky segment clipper, fully pipelined.
// Pipeline: capture (A), edge terms (B), divider chain, E1, E2, M, output register;
// the divider chain sets the depth. Reset sets busy; it clears once reset is released.
// Throughput: one segment per cycle while busy is low.
// Reset (synchronous, active low) clears all valid bits and loads the window.
// The receiver cannot stall; each result is shown for exactly one cycle.
module liang_barsky_line_clip_core
    import lbc_pkg::*;
#(
    parameter int FRACTION_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_seg        i_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  t_coord      i_cfg_data,
    output logic        o_valid,
    output t_clip       o_result
);

    localparam int FB     = FRACTION_BITS;
    localparam int DW     = CoordBits + 1;     // differences and magnitudes
    localparam int QW     = FB + 2;            // divider quotient
    localparam int RW     = FB + 3;            // signed ratio
    localparam int TW     = FB + 1;            // t0 / t1
    localparam int PW     = TW + DW;           // t * |delta|
    localparam int DivLat = FB + 2;

    localparam logic [QW-1:0] RCap = (QW'(1) << FB) + QW'(1);
    localparam logic [TW-1:0] TOne = TW'(1) << FB;
    localparam logic [PW:0]   Half = (PW+1)'(1) << (FB - 1);

    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [RW-1:0] t_ratio;

    typedef struct packed {
        t_seg       seg;
        t_diff      dx;
        t_diff      dy;
        logic [3:0] pneg;
        logic [3:0] pzero;
        logic [3:0] qneg;
        logic [3:0] sat;
    } t_side;

    typedef struct packed {
        logic          ok;
        logic [TW-1:0] t0;
        logic [TW-1:0] t1;
    } t_tpair;

    // narrow the entry/exit pair by one window edge
    function automatic t_tpair edge_step(input t_tpair tin, input logic pneg,
                                         input logic pzero, input logic qneg,
                                         input t_ratio r);
        t_tpair tout;
        t_ratio t0s;
        t_ratio t1s;
        tout = tin;
        t0s  = signed'({2'b00, tin.t0});
        t1s  = signed'({2'b00, tin.t1});
        if (pzero) begin
            if (qneg) tout.ok = 1'b0;
        end else if (pneg) begin
            if (r > t1s) tout.ok = 1'b0;
            else if (r > t0s) tout.t0 = r[TW-1:0];
        end else begin
            if (r < t0s) tout.ok = 1'b0;
            else if (r < t1s) tout.t1 = r[TW-1:0];
        end
        return tout;
    endfunction

    function automatic logic [DW-1:0] mag(input t_diff v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // ---------------- window registers ----------------
    t_coord r_win [4];
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[REG_LEFT]   <= WinLeftRst;
            r_win[REG_BOTTOM] <= WinBottomRst;
            r_win[REG_RIGHT]  <= WinRightRst;
            r_win[REG_TOP]    <= WinTopRst;
            r_busy            <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_LEFT:   r_win[REG_LEFT]   <= i_cfg_data;
                    REG_BOTTOM: r_win[REG_BOTTOM] <= i_cfg_data;
                    REG_RIGHT:  r_win[REG_RIGHT]  <= i_cfg_data;
                    REG_TOP:    r_win[REG_TOP]    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // ---------------- stage A: capture item ----------------
    logic r_a_valid;
    t_seg r_a_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else          r_a_valid <= start & ~r_busy;
        r_a_seg <= i_item;
    end

    // ---------------- stage B: edge terms p, q ----------------
    t_diff         sx, sy, ex, ey, xl, yb, xr, yt, dx, dy;
    t_diff         p [4];
    t_diff         q [4];
    t_side         n_b_side;
    logic [DW-1:0] n_num [4];
    logic [DW-1:0] n_den [4];

    always_comb begin
        sx = {r_a_seg.start_x[CoordBits-1], r_a_seg.start_x};
        sy = {r_a_seg.start_y[CoordBits-1], r_a_seg.start_y};
        ex = {r_a_seg.end_x[CoordBits-1], r_a_seg.end_x};
        ey = {r_a_seg.end_y[CoordBits-1], r_a_seg.end_y};
        xl = {r_win[REG_LEFT][CoordBits-1], r_win[REG_LEFT]};
        yb = {r_win[REG_BOTTOM][CoordBits-1], r_win[REG_BOTTOM]};
        xr = {r_win[REG_RIGHT][CoordBits-1], r_win[REG_RIGHT]};
        yt = {r_win[REG_TOP][CoordBits-1], r_win[REG_TOP]};
        dx = ex - sx;
        dy = ey - sy;
        // left, right, bottom, top
        p[0] = -dx;  q[0] = sx - xl;
        p[1] = dx;   q[1] = xr - sx;
        p[2] = -dy;  q[2] = sy - yb;
        p[3] = dy;   q[3] = yt - sy;
        n_b_side.seg = r_a_seg;
        n_b_side.dx  = dx;
        n_b_side.dy  = dy;
        for (int k = 0; k < 4; k++) begin
            n_num[k]             = mag(q[k]);
            n_den[k]             = mag(p[k]);
            n_b_side.pneg[k]     = p[k][DW-1];
            n_b_side.pzero[k]    = (p[k] == '0);
            n_b_side.qneg[k]     = q[k][DW-1];
            n_b_side.sat[k]      = ({2'b00, n_num[k]} >= {n_den[k], 2'b00});
        end
    end

    logic          r_b_valid;
    t_side         r_b_side;
    logic [DW-1:0] r_b_num [4];
    logic [DW-1:0] r_b_den [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_valid <= 1'b0;
        else          r_b_valid <= r_a_valid;
        r_b_side <= n_b_side;
        r_b_num  <= n_num;
        r_b_den  <= n_den;
    end

    // ---------------- divider stages ----------------
    logic [QW-1:0]     w_quo [4];
    t_side             r_d_side [DivLat];
    logic [DivLat-1:0] r_d_valid;

    for (genvar k = 0; k < 4; k++) begin : g_div
        lbc_div #(
            .MagBits  (DW),
            .FracBits (FB)
        ) u_div (
            .i_clk (i_clk),
            .i_num (r_b_num[k]),
            .i_den (r_b_den[k]),
            .o_quo (w_quo[k])
        );
    end

    // carry the side data alongside the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_valid <= '0;
        else          r_d_valid <= {r_d_valid[DivLat-2:0], r_b_valid};
        r_d_side[0] <= r_b_side;
        for (int j = 1; j < DivLat; j++) r_d_side[j] <= r_d_side[j-1];
    end

    // signed, saturated ratios
    t_side         d_side;
    t_ratio        rat [4];
    logic [QW-1:0] rmag;

    always_comb begin
        d_side = r_d_side[DivLat-1];
        for (int k = 0; k < 4; k++) begin
            rmag = (d_side.sat[k] || (w_quo[k] > RCap)) ? RCap : w_quo[k];
            rat[k] = (d_side.qneg[k] ^ d_side.pneg[k]) ? -t_ratio'({1'b0, rmag})
                                                        : t_ratio'({1'b0, rmag});
        end
    end

    // ---------------- stage E1: left and right edges ----------------
    t_tpair t_init;
    t_tpair n_e1_tp;

    always_comb begin
        t_init.ok = 1'b1;
        t_init.t0 = '0;
        t_init.t1 = TOne;
        n_e1_tp = edge_step(edge_step(t_init, d_side.pneg[0], d_side.pzero[0],
                                      d_side.qneg[0], rat[0]),
                            d_side.pneg[1], d_side.pzero[1], d_side.qneg[1], rat[1]);
    end

    logic   r_e1_valid;
    t_tpair r_e1_tp;
    t_side  r_e1_side;
    t_ratio r_e1_r2;
    t_ratio r_e1_r3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e1_valid <= 1'b0;
        else          r_e1_valid <= r_d_valid[DivLat-1];
        r_e1_tp   <= n_e1_tp;
        r_e1_side <= d_side;
        r_e1_r2   <= rat[2];
        r_e1_r3   <= rat[3];
    end

    // ---------------- stage E2: bottom and top edges ----------------
    t_tpair n_e2_tp;

    always_comb begin
        n_e2_tp = edge_step(edge_step(r_e1_tp, r_e1_side.pneg[2], r_e1_side.pzero[2],
                                      r_e1_side.qneg[2], r_e1_r2),
                            r_e1_side.pneg[3], r_e1_side.pzero[3],
                            r_e1_side.qneg[3], r_e1_r3);
    end

    logic   r_e2_valid;
    t_tpair r_e2_tp;
    t_side  r_e2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e2_valid <= 1'b0;
        else          r_e2_valid <= r_e1_valid;
        r_e2_tp   <= n_e2_tp;
        r_e2_side <= r_e1_side;
    end

    // ---------------- stage M: t * |delta| ----------------
    logic [PW-1:0] n_prod [4];
    logic [DW-1:0] adx, ady;

    always_comb begin
        adx = mag(r_e2_side.dx);
        ady = mag(r_e2_side.dy);
        n_prod[0] = PW'(r_e2_tp.t0) * PW'(adx);
        n_prod[1] = PW'(r_e2_tp.t0) * PW'(ady);
        n_prod[2] = PW'(r_e2_tp.t1) * PW'(adx);
        n_prod[3] = PW'(r_e2_tp.t1) * PW'(ady);
    end

    logic          r_m_valid;
    logic          r_m_ok;
    t_side         r_m_side;
    logic [PW-1:0] r_m_prod [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_valid <= 1'b0;
        else          r_m_valid <= r_e2_valid;
        r_m_ok   <= r_e2_tp.ok;
        r_m_side <= r_e2_side;
        r_m_prod <= n_prod;
    end

    // ---------------- stage R: round, offset, select ----------------
    logic                   rneg  [4];
    logic [PW:0]            rsum  [4];
    logic signed [DW+2:0]   rdel  [4];
    logic signed [DW+2:0]   rbase [4];
    logic signed [DW+2:0]   rpos  [4];
    t_clip                  n_out;

    always_comb begin
        rbase[0] = (DW+3)'(r_m_side.seg.start_x);
        rbase[1] = (DW+3)'(r_m_side.seg.start_y);
        rbase[2] = (DW+3)'(r_m_side.seg.start_x);
        rbase[3] = (DW+3)'(r_m_side.seg.start_y);
        rneg[0]  = r_m_side.dx[DW-1];
        rneg[1]  = r_m_side.dy[DW-1];
        rneg[2]  = r_m_side.dx[DW-1];
        rneg[3]  = r_m_side.dy[DW-1];
        for (int k = 0; k < 4; k++) begin
            // halves go toward plus infinity
            rsum[k] = {1'b0, r_m_prod[k]} + Half - (PW+1)'(rneg[k]);
            rdel[k] = rneg[k] ? -signed'({1'b0, rsum[k][PW:FB]})
                              : signed'({1'b0, rsum[k][PW:FB]});
            rpos[k] = rbase[k] + rdel[k];
        end
        if (r_m_ok) begin
            n_out.accepted     = 1'b1;
            n_out.clip_start_x = rpos[0][CoordBits-1:0];
            n_out.clip_start_y = rpos[1][CoordBits-1:0];
            n_out.clip_end_x   = rpos[2][CoordBits-1:0];
            n_out.clip_end_y   = rpos[3][CoordBits-1:0];
        end else begin
            n_out.accepted     = 1'b0;
            n_out.clip_start_x = r_m_side.seg.start_x;
            n_out.clip_start_y = r_m_side.seg.start_y;
            n_out.clip_end_x   = r_m_side.seg.end_x;
            n_out.clip_end_y   = r_m_side.seg.end_y;
        end
    end

    logic  r_out_valid;
    t_clip r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else          r_out_valid <= r_m_valid;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(FB + 8) o_valid)
        else $error("accepted item produced no result at expected latency");

    a_t_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e2_valid && r_e2_tp.ok) |-> (r_e2_tp.t0 <= r_e2_tp.t1))
        else $error("entry parameter exceeds exit parameter on accepted segment");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e2_valid |-> (r_e2_tp.t1 <= TOne))
        else $error("exit parameter above one");
`endif

endmodule
